FILE: hdl/tatm_pkg.sv
// Package for the two-axis trapezoidal move time core: widths, codes, result and cell types,
// and the single-step functions of the division and square-root cells.
// Depends on nothing; every other file imports it.
package tatm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;

    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int PITCH_W = VAL_W + 1;
    localparam int DIST_W  = PITCH_W + IDX_W;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SA_W    = DIST_W + VAL_W;
    localparam int QUO_W   = 2 * VAL_W;
    localparam int NUM_W   = QUO_W + VAL_W + 1;
    localparam int REM_W   = VAL_W + 2;
    localparam int ADDR_W  = 5;

    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_STEPS = VAL_W;

    // Every division produces a 64-bit quotient; the wanted fixed-point value is its upper half.
    localparam int SHIFT_DIV  = FRAC_BITS + QUO_W / 2;
    localparam int SHIFT_ROOT = 2 * FRAC_BITS + 2;

    localparam logic [VAL_W-1:0] FIX_ONE = VAL_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        REG_SEGMENT_GAP     = 3'd0,
        REG_SEGMENT_WIDTH   = 3'd1,
        REG_SEGMENT_HEIGHT  = 3'd2,
        REG_HORIZ_MAX_SPEED = 3'd3,
        REG_HORIZ_ACCEL     = 3'd4,
        REG_VERT_MAX_SPEED  = 3'd5,
        REG_VERT_ACCEL      = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_SUM    = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_ROOT   = 2'd2
    } t_mode;

    typedef struct packed {
        logic  zero;
        logic  pre_sat;
        t_mode mode;
        logic  sat_a;
        logic  sat_b;
    } t_div_side;

    typedef struct packed {
        logic [VAL_W-1:0] rem_a;
        logic [QUO_W-1:0] nq_a;
        logic [VAL_W-1:0] rem_b;
        logic [QUO_W-1:0] nq_b;
        t_div_side        side;
    } t_div_data;

    typedef struct packed {
        logic             use_root;
        logic             sat;
        logic [VAL_W-1:0] time_val;
    } t_root_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [VAL_W-1:0] root;
        logic [QUO_W-1:0] rad;
        t_root_side       side;
    } t_root_data;

    typedef struct packed {
        logic [VAL_W-1:0] rem;
        logic [QUO_W-1:0] nq;
    } t_div_pair;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [VAL_W-1:0] root;
        logic [QUO_W-1:0] rad;
    } t_root_pair;

    typedef struct packed {
        logic [VAL_W-1:0] time_val;
        logic             sat;
    } t_result;

    // One restoring division step: the numerator bits leave the top of nq while the
    // quotient bits enter at the bottom.
    function automatic t_div_pair div_step(input logic [VAL_W-1:0] rem,
                                           input logic [QUO_W-1:0] nq,
                                           input logic [VAL_W-1:0] den);
        logic [VAL_W:0] trial;
        logic           ge;
        t_div_pair      res;
        trial   = {rem, nq[QUO_W-1]};
        ge      = trial >= {1'b0, den};
        res.rem = ge ? VAL_W'(trial - {1'b0, den}) : trial[VAL_W-1:0];
        res.nq  = {nq[QUO_W-2:0], ge};
        return res;
    endfunction

    // One digit of the integer square root, two radicand bits per step.
    function automatic t_root_pair root_step(input logic [REM_W-1:0] rem,
                                             input logic [VAL_W-1:0] root,
                                             input logic [QUO_W-1:0] rad);
        logic [REM_W+1:0] cand;
        logic [REM_W+1:0] trial;
        logic             ge;
        t_root_pair       res;
        cand     = {rem, rad[QUO_W-1 -: 2]};
        trial    = {{(REM_W-VAL_W){1'b0}}, root, 2'b01};
        ge       = cand >= trial;
        res.rem  = ge ? REM_W'(cand - trial) : cand[REM_W-1:0];
        res.root = {root[VAL_W-2:0], ge};
        res.rad  = {rad[QUO_W-3:0], 2'b00};
        return res;
    endfunction

endpackage

FILE: hdl/tatm_div_cell.sv
// One cell of the division chain: a step of each of the two parallel restoring dividers.
// Depends on tatm_pkg for the cell data type and div_step.
module tatm_div_cell import tatm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [VAL_W-1:0] i_den_a,
    input  logic [VAL_W-1:0] i_den_b,
    input  logic             i_valid,
    input  t_div_data        i_data,
    output logic             o_valid,
    output t_div_data        o_data
);

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;
    t_div_pair step_a;
    t_div_pair step_b;

    always_comb begin
        step_a        = div_step(i_data.rem_a, i_data.nq_a, i_den_a);
        step_b        = div_step(i_data.rem_b, i_data.nq_b, i_den_b);
        n_data.rem_a  = step_a.rem;
        n_data.nq_a   = step_a.nq;
        n_data.rem_b  = step_b.rem;
        n_data.nq_b   = step_b.nq;
        n_data.side   = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/tatm_root_cell.sv
// One cell of the square-root chain: one result bit of the integer square root.
// Depends on tatm_pkg for the cell data type and root_step.
module tatm_root_cell import tatm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_root_data i_data,
    output logic       o_valid,
    output t_root_data o_data
);

    logic       r_valid;
    t_root_data r_data;
    t_root_data n_data;
    t_root_pair step;

    always_comb begin
        step        = root_step(i_data.rem, i_data.root, i_data.rad);
        n_data.rem  = step.rem;
        n_data.root = step.root;
        n_data.rad  = step.rad;
        n_data.side = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/tatm_axis.sv
// Move time of one axis: profile case selection, a chain of division cells and a chain of
// square-root cells. Depends on tatm_pkg, tatm_div_cell and tatm_root_cell.
module tatm_axis import tatm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIST_W-1:0] i_dist,
    input  logic [VAL_W-1:0]  i_speed,
    input  logic [VAL_W-1:0]  i_accel,
    output logic              o_valid,
    output t_result           o_result
);

    // Products stage
    logic              r_p_valid;
    logic [DIST_W-1:0] r_p_dist;
    logic [PROD_W-1:0] r_p_sa_lo;
    logic [DIST_W-1:0] r_p_sa_hi;
    logic [PROD_W-1:0] r_p_vv;

    // Case selection stage
    logic              r_m_valid;
    logic [DIST_W-1:0] r_m_dist;
    t_div_side         r_m_side;
    t_div_side         n_m_side;
    logic [SA_W-1:0]   sa;

    // Division set-up stage
    logic              r_i_valid;
    t_div_data         r_i_data;
    t_div_data         n_i_data;
    logic [NUM_W-1:0]  num_a;
    logic [NUM_W-1:0]  num_b;
    logic [VAL_W:0]    hi_a;
    logic [VAL_W:0]    hi_b;

    // Time composition stage
    logic              r_t_valid;
    t_root_data        r_t_data;
    t_root_data        n_t_data;
    logic [VAL_W-1:0]  qa_hi;
    logic [VAL_W-1:0]  qb_hi;
    logic [VAL_W:0]    qsum;
    t_div_side         end_side;

    logic              div_valid [DIV_STEPS+1];
    t_div_data         div_data  [DIV_STEPS+1];
    logic              root_valid [ROOT_STEPS+1];
    t_root_data        root_data  [ROOT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_i_valid <= 1'b0;
            r_t_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_m_valid <= r_p_valid;
            r_i_valid <= r_m_valid;
            r_t_valid <= div_valid[DIV_STEPS];
        end
    end

    // s*a is split into two partial products so that no multiplier exceeds 32 by 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_dist  <= i_dist;
            r_p_sa_lo <= PROD_W'(i_dist[VAL_W-1:0]) * PROD_W'(i_accel);
            r_p_sa_hi <= DIST_W'(i_dist[DIST_W-1:VAL_W]) * DIST_W'(i_accel);
            r_p_vv    <= PROD_W'(i_speed) * PROD_W'(i_speed);
        end
    end

    always_comb begin
        sa                = {r_p_sa_hi, VAL_W'(0)} + SA_W'(r_p_sa_lo);
        n_m_side.zero     = r_p_dist == '0;
        n_m_side.pre_sat  = (i_speed == '0) || (i_accel == '0);
        n_m_side.sat_a    = 1'b0;
        n_m_side.sat_b    = 1'b0;
        if (sa > SA_W'(r_p_vv)) begin
            n_m_side.mode = MODE_SUM;
        end else if (sa == SA_W'(r_p_vv)) begin
            n_m_side.mode = MODE_DOUBLE;
        end else begin
            n_m_side.mode = MODE_ROOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_dist <= r_p_dist;
            r_m_side <= n_m_side;
        end
    end

    // The part of a numerator above the quotient bits is the starting remainder; when it is
    // not below the divisor the quotient does not fit and the time saturates.
    always_comb begin
        case (r_m_side.mode)
            MODE_SUM:    num_a = NUM_W'(i_speed) << SHIFT_DIV;
            MODE_DOUBLE: num_a = NUM_W'(i_speed) << (SHIFT_DIV + 1);
            MODE_ROOT:   num_a = NUM_W'(r_m_dist) << SHIFT_ROOT;
            default:     num_a = '0;
        endcase
        num_b                = NUM_W'(r_m_dist) << SHIFT_DIV;
        hi_a                 = num_a[NUM_W-1:QUO_W];
        hi_b                 = num_b[NUM_W-1:QUO_W];
        n_i_data.rem_a       = hi_a[VAL_W-1:0];
        n_i_data.nq_a        = num_a[QUO_W-1:0];
        n_i_data.rem_b       = hi_b[VAL_W-1:0];
        n_i_data.nq_b        = num_b[QUO_W-1:0];
        n_i_data.side        = r_m_side;
        n_i_data.side.sat_a  = hi_a >= {1'b0, i_accel};
        n_i_data.side.sat_b  = hi_b >= {1'b0, i_speed};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i_data <= n_i_data;
        end
    end

    assign div_valid[0] = r_i_valid;
    assign div_data[0]  = r_i_data;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        tatm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_den_a (i_accel),
            .i_den_b (i_speed),
            .i_valid (div_valid[k]),
            .i_data  (div_data[k]),
            .o_valid (div_valid[k+1]),
            .o_data  (div_data[k+1])
        );
    end

    always_comb begin
        end_side                 = div_data[DIV_STEPS].side;
        qa_hi                    = div_data[DIV_STEPS].nq_a[QUO_W-1 -: VAL_W];
        qb_hi                    = div_data[DIV_STEPS].nq_b[QUO_W-1 -: VAL_W];
        qsum                     = (VAL_W+1)'(qa_hi) + (VAL_W+1)'(qb_hi);
        n_t_data.rem             = '0;
        n_t_data.root            = '0;
        n_t_data.rad             = div_data[DIV_STEPS].nq_a;
        n_t_data.side.use_root   = 1'b0;
        n_t_data.side.sat        = 1'b0;
        n_t_data.side.time_val   = '0;
        if (end_side.zero) begin
            n_t_data.side.sat    = 1'b0;
        end else if (end_side.pre_sat) begin
            n_t_data.side.sat    = 1'b1;
        end else begin
            case (end_side.mode)
                MODE_SUM: begin
                    n_t_data.side.sat      = end_side.sat_a | end_side.sat_b | qsum[VAL_W];
                    n_t_data.side.time_val = qsum[VAL_W-1:0];
                end
                MODE_DOUBLE: begin
                    n_t_data.side.sat      = end_side.sat_a;
                    n_t_data.side.time_val = qa_hi;
                end
                MODE_ROOT: begin
                    n_t_data.side.sat      = end_side.sat_a;
                    n_t_data.side.use_root = 1'b1;
                end
                default: begin
                    n_t_data.side.sat      = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_data <= n_t_data;
        end
    end

    assign root_valid[0] = r_t_valid;
    assign root_data[0]  = r_t_data;

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        tatm_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (root_valid[k]),
            .i_data  (root_data[k]),
            .o_valid (root_valid[k+1]),
            .o_data  (root_data[k+1])
        );
    end

    assign o_valid           = root_valid[ROOT_STEPS];
    assign o_result.sat      = root_data[ROOT_STEPS].side.sat;
    assign o_result.time_val = root_data[ROOT_STEPS].side.use_root ?
                               root_data[ROOT_STEPS].root : root_data[ROOT_STEPS].side.time_val;

endmodule

FILE: hdl/two_axis_trapezoid_move_time_core.sv
// Throughput: one item per cycle while the skid entry is free; the depth is set by the 64 division cells and the
// 32 square-root cells of each axis, which all advance together.
// Output register plus skid entry: the pipeline keeps taking items until the skid entry is full.
// Reset is synchronous, active low: it empties the pipeline and loads the register reset values.
// Depends on tatm_pkg and tatm_axis.
module two_axis_trapezoid_move_time_core import tatm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IDX_W-1:0]  i_from_row,
    input  logic [IDX_W-1:0]  i_from_column,
    input  logic [IDX_W-1:0]  i_to_row,
    input  logic [IDX_W-1:0]  i_to_column,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VAL_W-1:0]  o_travel_time,
    output logic              o_time_saturated,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [VAL_W-1:0]  pwdata,
    output logic [VAL_W-1:0]  prdata,
    output logic              pready
);

    logic [VAL_W-1:0] r_segment_gap;
    logic [VAL_W-1:0] r_segment_width;
    logic [VAL_W-1:0] r_segment_height;
    logic [VAL_W-1:0] r_horiz_max_speed;
    logic [VAL_W-1:0] r_horiz_accel;
    logic [VAL_W-1:0] r_vert_max_speed;
    logic [VAL_W-1:0] r_vert_accel;
    t_reg_idx         reg_idx;
    logic             cfg_write;

    logic               en;
    logic               r_s0_valid;
    logic [IDX_W-1:0]   r_s0_from_row;
    logic [IDX_W-1:0]   r_s0_from_column;
    logic [IDX_W-1:0]   r_s0_to_row;
    logic [IDX_W-1:0]   r_s0_to_column;
    logic               r_s1_valid;
    logic [IDX_W-1:0]   r_s1_dc;
    logic [IDX_W-1:0]   r_s1_dr;
    logic [PITCH_W-1:0] r_s1_pitch;
    logic               r_s2_valid;
    logic [DIST_W-1:0]  r_s2_sh;
    logic [DIST_W-1:0]  r_s2_sv;

    logic    h_valid;
    logic    v_valid;
    t_result h_result;
    t_result v_result;
    logic    r_f_valid;
    t_result r_f_result;
    t_result n_f_result;
    logic    push;

    logic    r_out_valid;
    t_result r_out_result;
    logic    r_skid_valid;
    t_result r_skid_result;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_gap     <= '0;
            r_segment_width   <= FIX_ONE;
            r_segment_height  <= FIX_ONE;
            r_horiz_max_speed <= FIX_ONE;
            r_horiz_accel     <= FIX_ONE;
            r_vert_max_speed  <= FIX_ONE;
            r_vert_accel      <= FIX_ONE;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_SEGMENT_GAP:     r_segment_gap     <= pwdata;
                REG_SEGMENT_WIDTH:   r_segment_width   <= pwdata;
                REG_SEGMENT_HEIGHT:  r_segment_height  <= pwdata;
                REG_HORIZ_MAX_SPEED: r_horiz_max_speed <= pwdata;
                REG_HORIZ_ACCEL:     r_horiz_accel     <= pwdata;
                REG_VERT_MAX_SPEED:  r_vert_max_speed  <= pwdata;
                REG_VERT_ACCEL:      r_vert_accel      <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SEGMENT_GAP:     prdata = r_segment_gap;
            REG_SEGMENT_WIDTH:   prdata = r_segment_width;
            REG_SEGMENT_HEIGHT:  prdata = r_segment_height;
            REG_HORIZ_MAX_SPEED: prdata = r_horiz_max_speed;
            REG_HORIZ_ACCEL:     prdata = r_horiz_accel;
            REG_VERT_MAX_SPEED:  prdata = r_vert_max_speed;
            REG_VERT_ACCEL:      prdata = r_vert_accel;
            default:             prdata = '0;
        endcase
    end

    // The whole pipeline moves while the skid entry is free.
    assign en      = !r_skid_valid;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_f_valid  <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_f_valid  <= h_valid;
        end
    end

    // Indices beyond the grid are pulled back to its last row or column.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_from_row    <= (32'(i_from_row) >= MAX_ROWS) ?
                                IDX_W'(MAX_ROWS - 1) : i_from_row;
            r_s0_from_column <= (32'(i_from_column) >= MAX_COLUMNS) ?
                                IDX_W'(MAX_COLUMNS - 1) : i_from_column;
            r_s0_to_row      <= (32'(i_to_row) >= MAX_ROWS) ?
                                IDX_W'(MAX_ROWS - 1) : i_to_row;
            r_s0_to_column   <= (32'(i_to_column) >= MAX_COLUMNS) ?
                                IDX_W'(MAX_COLUMNS - 1) : i_to_column;
            r_s1_dc          <= (r_s0_from_column > r_s0_to_column) ?
                                r_s0_from_column - r_s0_to_column :
                                r_s0_to_column - r_s0_from_column;
            r_s1_dr          <= (r_s0_from_row > r_s0_to_row) ?
                                r_s0_from_row - r_s0_to_row :
                                r_s0_to_row - r_s0_from_row;
            r_s1_pitch       <= PITCH_W'(r_segment_gap) + PITCH_W'(r_segment_width);
            r_s2_sh          <= DIST_W'(r_s1_dc) * DIST_W'(r_s1_pitch);
            r_s2_sv          <= DIST_W'(r_s1_dr) * DIST_W'(r_segment_height);
        end
    end

    tatm_axis u_horiz (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s2_valid),
        .i_dist   (r_s2_sh),
        .i_speed  (r_horiz_max_speed),
        .i_accel  (r_horiz_accel),
        .o_valid  (h_valid),
        .o_result (h_result)
    );

    tatm_axis u_vert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s2_valid),
        .i_dist   (r_s2_sv),
        .i_speed  (r_vert_max_speed),
        .i_accel  (r_vert_accel),
        .o_valid  (v_valid),
        .o_result (v_result)
    );

    always_comb begin
        n_f_result.sat = h_result.sat | v_result.sat;
        if (n_f_result.sat) begin
            n_f_result.time_val = '1;
        end else if (h_result.time_val > v_result.time_val) begin
            n_f_result.time_val = h_result.time_val;
        end else begin
            n_f_result.time_val = v_result.time_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_result <= n_f_result;
        end
    end

    // Output register with a skid entry behind it.
    assign push = en && r_f_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_result <= r_skid_result;
            end else if (push) begin
                r_out_result <= r_f_result;
            end
        end else if (push) begin
            r_skid_result <= r_f_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_travel_time    = r_out_result.time_val;
    assign o_time_saturated = r_out_result.sat;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid entry filled although the output item was taken");

    a_axes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_valid == v_valid)
        else $error("horizontal and vertical axis pipelines out of step");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_time_saturated) |-> (o_travel_time == '1))
        else $error("saturated item without full-scale time");
`endif

endmodule
